// ----- rtl/core/ternary_search_sorted_table_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Ternary search table unit: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TERNARY_SEARCH_SORTED_TABLE_UNIT_DEFINES_SVH
`define TERNARY_SEARCH_SORTED_TABLE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TSST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/tsst_pkg.sv -----
// ----------------------------------------------------------------------------
// Ternary search table unit: package
// Widths, constants, beat types and sequencer states shared by the block.
// ----------------------------------------------------------------------------
package tsst_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int INDEX_W     = 8;
  localparam int COUNT_W     = 9;
  localparam int VALUE_W     = 32;
  // Signed range bounds: high may reach -1 and low may reach TABLE_DEPTH.
  localparam int RANGE_W     = 10;
  localparam int THIRD_W     = 7;
  // span / 3 == (span * RECIP_3) >> RECIP_SHIFT for every span below 512.
  localparam int RECIP_3     = 171;
  localparam int RECIP_SHIFT = 9;
  localparam int PROD_W      = 16;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef struct packed {
    op_t                        operation;
    logic [INDEX_W-1:0]         entry_index;
    logic signed [VALUE_W-1:0]  entry_value;
    logic signed [VALUE_W-1:0]  search_key;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] match_index;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_RD1,
    S_RD2,
    S_CMP,
    S_DONE
  } state_t;

endpackage

// ----- rtl/core/tsst_ram.sv -----
// ----------------------------------------------------------------------------
// Ternary search table unit: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tsst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/ternary_search_sorted_table_unit.sv -----
// ----------------------------------------------------------------------------
// Ternary search table unit
// Sorted table of signed 32-bit entries with an iterative ternary search.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_* sets entry_count, the number of entries searched (values above 256
//   act as 256). It is always ready and should be written while idle.
//   in_* carries load and search beats. A load writes one table entry in the
//   cycle it is accepted and produces no result; the next beat may follow at
//   once. A search produces one out_* beat with found and match_index.
//   Each ternary step runs through S_PROBE, S_RD1, S_RD2 and S_CMP: the
//   divide-by-three of the span through the shared constant multiplier,
//   then two reads of the single table read port, then the compare. A hit
//   goes on to S_DONE; a miss first passes S_PROBE once more. A full
//   256-entry table needs at most six steps. in_ready is low while a search
//   runs; the next beat is taken in the cycle after the result is registered.
//   Reset clears entry_count and the control state; the table contents are
//   undefined until loaded and no clearing pass runs. If the receiver stalls,
//   the result waits in the output register and the block still takes loads;
//   a later search finishes and holds until the output register frees up.
// ----------------------------------------------------------------------------
`include "ternary_search_sorted_table_unit_defines.svh"

module ternary_search_sorted_table_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tsst_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tsst_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tsst_pkg::COUNT_W-1:0]        cfg_data
);

  tsst_pkg::state_t state;
  tsst_pkg::state_t state_next;

  logic [tsst_pkg::COUNT_W-1:0]        entry_count;
  logic [tsst_pkg::COUNT_W-1:0]        n_clamp;
  logic signed [tsst_pkg::VALUE_W-1:0] key;
  logic signed [tsst_pkg::RANGE_W-1:0] low;
  logic signed [tsst_pkg::RANGE_W-1:0] high;
  logic signed [tsst_pkg::RANGE_W-1:0] span;
  logic signed [tsst_pkg::RANGE_W-1:0] m1;
  logic signed [tsst_pkg::RANGE_W-1:0] m2;
  logic [tsst_pkg::THIRD_W-1:0]        third;
  logic [tsst_pkg::PROD_W-1:0]         prod;
  logic signed [tsst_pkg::VALUE_W-1:0] v1;
  logic signed [tsst_pkg::VALUE_W-1:0] v2;
  logic [tsst_pkg::VALUE_W-1:0]        rdata;
  logic [tsst_pkg::INDEX_W-1:0]        raddr;
  logic                                load_we;
  logic                                in_fire;
  logic                                push;
  logic                                res_found;
  logic [tsst_pkg::INDEX_W-1:0]        res_index;
  logic                                hit1;
  logic                                hit2;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == tsst_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign load_we   = in_fire && (in_data.operation == tsst_pkg::OP_LOAD);

  assign n_clamp = (entry_count > tsst_pkg::COUNT_W'(tsst_pkg::TABLE_DEPTH)) ?
                   tsst_pkg::COUNT_W'(tsst_pkg::TABLE_DEPTH) : entry_count;

  // Shared divide-by-three: constant reciprocal multiply on the live span.
  assign span = high - low;
  assign prod = tsst_pkg::PROD_W'(span[tsst_pkg::INDEX_W-1:0]) *
                tsst_pkg::PROD_W'(tsst_pkg::RECIP_3);

  assign m1 = low + $signed({3'b000, third});
  assign m2 = high - $signed({3'b000, third});

  assign raddr = (state == tsst_pkg::S_RD1) ? m1[tsst_pkg::INDEX_W-1:0] :
                                              m2[tsst_pkg::INDEX_W-1:0];
  assign v2    = $signed(rdata);
  assign hit1  = (v1 == key);
  assign hit2  = (v2 == key);
  assign push  = (state == tsst_pkg::S_DONE) && (!out_valid || out_ready);

  tsst_ram #(
    .WIDTH (tsst_pkg::VALUE_W),
    .DEPTH (tsst_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (load_we),
    .waddr (in_data.entry_index),
    .wdata (in_data.entry_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      tsst_pkg::S_IDLE: begin
        if (in_fire && (in_data.operation == tsst_pkg::OP_SEARCH)) begin
          state_next = tsst_pkg::S_PROBE;
        end
      end
      tsst_pkg::S_PROBE: begin
        state_next = (low <= high) ? tsst_pkg::S_RD1 : tsst_pkg::S_DONE;
      end
      tsst_pkg::S_RD1: state_next = tsst_pkg::S_RD2;
      tsst_pkg::S_RD2: state_next = tsst_pkg::S_CMP;
      tsst_pkg::S_CMP: begin
        state_next = (hit1 || hit2) ? tsst_pkg::S_DONE : tsst_pkg::S_PROBE;
      end
      tsst_pkg::S_DONE: begin
        if (push) begin
          state_next = tsst_pkg::S_IDLE;
        end
      end
      default: state_next = tsst_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tsst_pkg::S_IDLE;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        entry_count <= cfg_data;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data.found       <= res_found;
      out_data.match_index <= res_index;
    end
    case (state)
      tsst_pkg::S_IDLE: begin
        key       <= in_data.search_key;
        low       <= '0;
        high      <= $signed({1'b0, n_clamp}) - tsst_pkg::RANGE_W'(1);
        res_found <= 1'b0;
        res_index <= '0;
      end
      tsst_pkg::S_PROBE: begin
        third <= prod[tsst_pkg::RECIP_SHIFT +: tsst_pkg::THIRD_W];
      end
      tsst_pkg::S_RD2: begin
        v1 <= $signed(rdata);
      end
      tsst_pkg::S_CMP: begin
        if (hit1) begin
          res_found <= 1'b1;
          res_index <= m1[tsst_pkg::INDEX_W-1:0];
        end else if (hit2) begin
          res_found <= 1'b1;
          res_index <= m2[tsst_pkg::INDEX_W-1:0];
        end else if (key < v1) begin
          high <= m1 - tsst_pkg::RANGE_W'(1);
        end else if (key > v2) begin
          low <= m2 + tsst_pkg::RANGE_W'(1);
        end else begin
          low  <= m1 + tsst_pkg::RANGE_W'(1);
          high <= m2 - tsst_pkg::RANGE_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Both probes must lie inside the live range, in order.
  `TSST_ASSERT_SAME(a_probe_in_range, state == tsst_pkg::S_RD1, (m1 <= m2) && (m1 >= low) && (m2 <= high), "probe points outside search range")

  // Every step that continues must shrink the range.
  `TSST_ASSERT_NEXT(a_range_shrinks, (state == tsst_pkg::S_CMP) && (state_next == tsst_pkg::S_PROBE), (high - low) < ($past(high) - $past(low)), "search range did not shrink")

  // A miss reports index zero.
  `TSST_ASSERT_SAME(a_miss_index_zero, out_valid && !out_data.found, out_data.match_index == '0, "miss beat carries nonzero index")

  // A hit points inside the table in use.
  `TSST_ASSERT_SAME(a_hit_in_table, out_valid && out_data.found, tsst_pkg::COUNT_W'(out_data.match_index) < n_clamp, "hit index beyond entry count")

endmodule
